// ----- sv/jacobian_hessian_chain_order_dp_macros.svh -----
// assertion helpers used by the top-level rtl file
`ifndef JACOBIAN_HESSIAN_CHAIN_ORDER_DP_MACROS_SVH
`define JACOBIAN_HESSIAN_CHAIN_ORDER_DP_MACROS_SVH

// same-cycle implication, checked out of reset
`define JHCO_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define JHCO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/jhco_pkg.sv -----
package jhco_pkg;

  localparam int MAX_CHAIN_DEF = 16;
  localparam int DIM_BITS_DEF  = 16;
  localparam int IN_DIM_W      = 16;
  localparam int COST_W        = 64;
  localparam int SPLIT_W       = 6;

  // sequencer states of the dp engine
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CELL,
    ST_CELL2,
    ST_K_RD1,
    ST_K_RD2,
    ST_K_M1,
    ST_K_M2,
    ST_K_M3,
    ST_K_M4,
    ST_K_SUM,
    ST_WR,
    ST_FIN
  } eng_state_t;

  // control from the stream side to the engine
  typedef struct packed {
    logic start;
    logic ack;
  } eng_ctl_t;

  // finished plan
  typedef struct packed {
    logic [COST_W-1:0]  hess;
    logic [COST_W-1:0]  jac;
    logic [SPLIT_W-1:0] split;
  } eng_res_t;

endpackage

// ----- sv/jhco_dp_engine.sv -----
module jhco_dp_engine
  import jhco_pkg::*;
#(
  parameter int MAX_CHAIN = MAX_CHAIN_DEF,
  parameter int DIM_BITS  = DIM_BITS_DEF,
  parameter int IDX_W     = (MAX_CHAIN > 1) ? $clog2(MAX_CHAIN) : 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                ld_we,
  input  logic [IDX_W-1:0]    ld_addr,
  input  logic [DIM_BITS-1:0] ld_row,
  input  logic [DIM_BITS-1:0] ld_col,
  input  logic [IDX_W-1:0]    last_idx,
  input  eng_ctl_t            ctl,
  output logic                done,
  output eng_res_t            res
);

  localparam int AW = 2 * IDX_W;

  // factor stores and cost tables
  logic [DIM_BITS-1:0] row_mem [MAX_CHAIN];
  logic [DIM_BITS-1:0] col_mem [MAX_CHAIN];
  logic [COST_W-1:0]   jac_mem [2**AW];
  logic [COST_W-1:0]   hess_mem [2**AW];

  logic [DIM_BITS-1:0] row_q_r, col_q_r;
  logic [COST_W-1:0]   jac_q_r, hess_q_r;
  logic [IDX_W-1:0]    row_ra, col_ra;
  logic [AW-1:0]       tab_ra;
  logic                tab_we;

  eng_state_t state_r, state_nxt;

  logic [IDX_W-1:0] j_r, i_r, k_r, last_r, sp_r;
  logic [DIM_BITS-1:0] rj_r, ci_r, rk1_r, ck_r;
  logic [DIM_BITS:0] cc_r;
  logic [2*DIM_BITS-1:0] m1_r;
  logic [COST_W-1:0] jjk_r, hjk_r, jki_r, hki_r, base_r, t1_r, t2_r, jc_r, a_r;
  logic [COST_W-1:0] bj_r, bh_r;

  logic [3*DIM_BITS-1:0]         prod3;
  logic [COST_W+DIM_BITS-1:0]    pt1;
  logic [COST_W+DIM_BITS:0]      pt2;
  logic [COST_W-1:0]             ht;
  logic [IDX_W-1:0]              km1;
  logic                          first_k;
  logic [SPLIT_W:0]              sp_ext;

  assign km1     = k_r - 1'b1;
  assign first_k = (k_r == IDX_W'(i_r + 1'b1));
  assign prod3   = m1_r * ci_r;
  assign pt1     = base_r * ci_r;
  assign pt2     = base_r * cc_r;
  assign ht      = a_r + hjk_r + jki_r + t2_r;

  // read address selection
  always_comb begin
    row_ra = j_r;
    col_ra = i_r;
    tab_ra = {j_r, k_r};
    unique case (state_r)
      ST_K_RD1: begin
        row_ra = km1;
        col_ra = k_r;
        tab_ra = {j_r, k_r};
      end
      ST_K_RD2: tab_ra = {km1, i_r};
      default: ;
    endcase
  end

  // factor stores
  always_ff @(posedge clk) begin
    if (ld_we) begin
      row_mem[ld_addr] <= ld_row;
      col_mem[ld_addr] <= ld_col;
    end
    row_q_r <= row_mem[row_ra];
    col_q_r <= col_mem[col_ra];
  end

  // cost tables
  always_ff @(posedge clk) begin
    if (tab_we) begin
      jac_mem[{j_r, i_r}]  <= bj_r;
      hess_mem[{j_r, i_r}] <= bh_r;
    end
    jac_q_r  <= jac_mem[tab_ra];
    hess_q_r <= hess_mem[tab_ra];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (ctl.start) state_nxt = ST_CELL;
      ST_CELL:  state_nxt = ST_CELL2;
      ST_CELL2: state_nxt = (i_r == j_r) ? ST_WR : ST_K_RD1;
      ST_K_RD1: state_nxt = ST_K_RD2;
      ST_K_RD2: state_nxt = ST_K_M1;
      ST_K_M1:  state_nxt = ST_K_M2;
      ST_K_M2:  state_nxt = ST_K_M3;
      ST_K_M3:  state_nxt = ST_K_M4;
      ST_K_M4:  state_nxt = ST_K_SUM;
      ST_K_SUM: state_nxt = (k_r == j_r) ? ST_WR : ST_K_RD1;
      ST_WR:    state_nxt = (i_r == '0 && j_r == last_r) ? ST_FIN : ST_CELL;
      ST_FIN:   if (ctl.ack) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    tab_we = (state_r == ST_WR);
    done   = (state_r == ST_FIN);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // interval walk and split evaluation
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        j_r    <= '0;
        i_r    <= '0;
        last_r <= last_idx;
      end
      ST_CELL2: begin
        rj_r <= row_q_r;
        ci_r <= col_q_r;
        if (i_r == j_r) begin
          bj_r <= '0;
          bh_r <= '0;
          sp_r <= '0;
        end else begin
          k_r <= IDX_W'(i_r + 1'b1);
        end
      end
      ST_K_RD2: begin
        rk1_r <= row_q_r;
        ck_r  <= col_q_r;
        jjk_r <= jac_q_r;
        hjk_r <= hess_q_r;
      end
      ST_K_M1: begin
        jki_r <= jac_q_r;
        hki_r <= hess_q_r;
        m1_r  <= rj_r * rk1_r;
      end
      ST_K_M2: begin
        base_r <= COST_W'(prod3);
        cc_r   <= {1'b0, ck_r} + {1'b0, ci_r};
      end
      ST_K_M3: begin
        t1_r <= pt1[COST_W-1:0];
        jc_r <= jjk_r + jki_r + base_r;
      end
      ST_K_M4: begin
        t2_r <= pt2[COST_W-1:0];
        a_r  <= jjk_r + hki_r + t1_r;
      end
      ST_K_SUM: begin
        // smallest split wins a tie
        if (first_k || jc_r < bj_r) bj_r <= jc_r;
        if (first_k || ht < bh_r) begin
          bh_r <= ht;
          sp_r <= k_r;
        end
        if (k_r != j_r) k_r <= k_r + 1'b1;
      end
      ST_WR: begin
        if (i_r == '0) begin
          j_r <= j_r + 1'b1;
          i_r <= j_r + 1'b1;
        end else begin
          i_r <= i_r - 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign sp_ext    = (SPLIT_W + 1)'(sp_r);
  assign res.hess  = bh_r;
  assign res.jac   = bj_r;
  assign res.split = sp_ext[SPLIT_W-1:0];

endmodule

// ----- sv/jacobian_hessian_chain_order_dp.sv -----
// Chain cost planner. Each input transaction carries one Jacobian factor
// (rows, cols); tlast closes the chain. Factors past MAX_CHAIN are dropped and
// reported in out_tuser. After the closing factor the engine walks every
// subchain (j ascending, i descending) and every split k, computing the
// Jacobian and Hessian costs together; both tables live in one-read,
// one-write synchronous memories. Each split steps through two table reads,
// four serialized multiplies, sums and compare; each cell adds its own read,
// capture and write states. Inputs are held off until the engine's result is
// taken into the result register. Loading accepts one factor per cycle while
// no plan is running. The result register lets the next chain load while a
// result waits.
module jacobian_hessian_chain_order_dp
  import jhco_pkg::*;
#(
  parameter int MAX_CHAIN = MAX_CHAIN_DEF,
  parameter int DIM_BITS  = DIM_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [31:0]  in_tdata,   // factor_rows[15:0], factor_cols[31:16]
  input  logic         in_tlast,   // last_factor
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [135:0] out_tdata,  // hessian_best_cost[63:0],
                                   // jacobian_best_cost[127:64], top_split[133:128]
  output logic         out_tuser   // too_long
);

  `include "jacobian_hessian_chain_order_dp_macros.svh"

  localparam int IDX_W = (MAX_CHAIN > 1) ? $clog2(MAX_CHAIN) : 1;
  localparam int CNT_W = $clog2(MAX_CHAIN + 1);

  logic [CNT_W-1:0] count_r;
  logic             ovf_r, busy_r, out_valid_r;
  eng_res_t         out_res_r;
  logic             out_user_r;

  logic             accept, take, done, room;
  logic [31:0]      rows_ext, cols_ext;
  logic [IDX_W-1:0] last_idx;
  eng_ctl_t         ctl;
  eng_res_t         res;

  assign in_tready = !busy_r;
  assign accept    = in_tvalid && in_tready;
  assign room      = (count_r < CNT_W'(MAX_CHAIN));
  assign take      = done && (!out_valid_r || out_tready);
  assign rows_ext  = {16'b0, in_tdata[15:0]};
  assign cols_ext  = {16'b0, in_tdata[31:16]};
  assign last_idx  = room ? count_r[IDX_W-1:0] : IDX_W'(MAX_CHAIN - 1);
  assign ctl.start = accept && in_tlast;
  assign ctl.ack   = take;

  jhco_dp_engine #(
    .MAX_CHAIN(MAX_CHAIN),
    .DIM_BITS (DIM_BITS)
  ) u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .ld_we   (accept && room),
    .ld_addr (count_r[IDX_W-1:0]),
    .ld_row  (rows_ext[DIM_BITS-1:0]),
    .ld_col  (cols_ext[DIM_BITS-1:0]),
    .last_idx(last_idx),
    .ctl     (ctl),
    .done    (done),
    .res     (res)
  );

  // chain load bookkeeping and result hand-off
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ovf_r       <= 1'b0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        if (room) count_r <= count_r + 1'b1;
        else ovf_r <= 1'b1;
        if (in_tlast) busy_r <= 1'b1;
      end
      if (take) begin
        out_valid_r <= 1'b1;
        busy_r      <= 1'b0;
        count_r     <= '0;
        ovf_r       <= 1'b0;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (take) begin
      out_res_r  <= res;
      out_user_r <= ovf_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b0, out_res_r.split, out_res_r.jac, out_res_r.hess};
  assign out_tuser  = out_user_r;

  // checks
  `JHCO_ASSERT_NOW(a_count_range, 1'b1, count_r <= CNT_W'(MAX_CHAIN), "chain count past limit")
  `JHCO_ASSERT_NEXT(a_last_busy, accept && in_tlast, busy_r, "closing factor did not start plan")
  `JHCO_ASSERT_NEXT(a_take_clear, take, count_r == '0 && !ovf_r && !busy_r, "chain state not cleared")
  `JHCO_ASSERT_NOW(a_done_busy, done, busy_r, "engine done without a chain")

endmodule

// ----- bench/jacobian_hessian_chain_order_dp_test.sv -----
module jacobian_hessian_chain_order_dp_test;
  import jhco_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAXC = MAX_CHAIN_DEF;
  localparam int DIMB = DIM_BITS_DEF;

  typedef struct packed {
    logic        last;
    logic [15:0] cols;
    logic [15:0] rows;
  } factor_t;

  typedef struct packed {
    logic [63:0] hess;
    logic [63:0] jac;
    logic [5:0]  split;
    logic        too_long;
  } plan_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [31:0]  in_tdata;
  logic         in_tlast;
  logic         out_tvalid;
  logic         out_tready;
  logic [135:0] out_tdata;
  logic         out_tuser;

  factor_t pending_factors[$];
  plan_t   expected_plans[$];
  logic [63:0] chain_rows[MAXC];
  logic [63:0] chain_cols[MAXC];
  int      chain_len = 0;
  logic    chain_dropped = 1'b0;
  int      error_count = 0;
  int      plan_count = 0;
  int      factor_count = 0;
  logic    quiet_mode;

  jacobian_hessian_chain_order_dp DUT (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  // clock
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    error_count++;
    $display("mismatch %s: got %0h, expected %0h (plan %0d)", what, got, want, plan_count);
  endtask

  // interval dp over the stored chain, both tables at once
  function automatic plan_t plan_chain();
    logic [63:0] jc[MAXC][MAXC];
    logic [63:0] hc[MAXC][MAXC];
    logic [5:0]  sp[MAXC][MAXC];
    logic [63:0] best, base, t;
    logic [5:0]  bk;
    plan_t       res;
    for (int j = 0; j < chain_len; j++) begin
      for (int i = j; i >= 0; i--) begin
        best = 0;
        bk = 0;
        for (int k = i + 1; k <= j; k++) begin
          t = jc[j][k] + jc[k-1][i] + chain_rows[j] * chain_rows[k-1] * chain_cols[i];
          if (k == i + 1 || t < best) best = t;
        end
        jc[j][i] = best;
        best = 0;
        for (int k = i + 1; k <= j; k++) begin
          base = chain_rows[j] * chain_rows[k-1] * chain_cols[i];
          t = jc[j][k] + hc[k-1][i] + base * chain_cols[i]
            + hc[j][k] + jc[k-1][i] + base * (chain_cols[k] + chain_cols[i]);
          if (k == i + 1 || t < best) begin
            best = t;
            bk = 6'(k);
          end
        end
        hc[j][i] = best;
        sp[j][i] = bk;
      end
    end
    res.hess = hc[chain_len-1][0];
    res.jac = jc[chain_len-1][0];
    res.split = sp[chain_len-1][0];
    res.too_long = chain_dropped;
    return res;
  endfunction

  // store a factor and predict the plan on the closing one
  function automatic void accept_factor(input factor_t f);
    if (chain_len < MAXC) begin
      chain_rows[chain_len] = 64'(f.rows & 16'((1 << DIMB) - 1));
      chain_cols[chain_len] = 64'(f.cols & 16'((1 << DIMB) - 1));
      chain_len++;
    end else begin
      chain_dropped = 1'b1;
    end
    if (f.last) begin
      expected_plans = {expected_plans, plan_chain()};
      chain_len = 0;
      chain_dropped = 1'b0;
    end
  endfunction

  function automatic logic [15:0] rand_dim(input int mode);
    case (mode)
      0: return 16'($urandom_range(0, 3));
      1: return 16'($urandom_range(0, 255));
      2: return 16'($urandom_range(65000, 65535));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_chain(input int len, input int mode);
    factor_t f;
    for (int n = 0; n < len; n++) begin
      f.rows = rand_dim(mode);
      f.cols = rand_dim(mode);
      f.last = (n == len - 1);
      pending_factors = {pending_factors, f};
    end
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      in_tlast <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        accept_factor(pending_factors.pop_front());
        factor_count++;
      end
      // hold a waiting transaction, otherwise offer the next one or idle
      if (!in_tvalid || in_tready) begin
        if (pending_factors.size() > 0 && (quiet_mode || $urandom_range(0, 99) >= 17))
        begin
          in_tvalid <= 1'b1;
          {in_tlast, in_tdata} <= pending_factors[0];
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and output stall
  always @(posedge clk) begin
    plan_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = {out_tdata[63:0], out_tdata[127:64], out_tdata[133:128], out_tuser};
        if (expected_plans.size() == 0) begin
          report_mismatch("unexpected result", got.hess, 64'd0);
        end else begin
          want = expected_plans.pop_front();
          if (got.hess !== want.hess) report_mismatch("hessian_best_cost", got.hess, want.hess);
          if (got.jac !== want.jac) report_mismatch("jacobian_best_cost", got.jac, want.jac);
          if (got.split !== want.split)
            report_mismatch("top_split", 64'(got.split), 64'(want.split));
          if (got.too_long !== want.too_long)
            report_mismatch("too_long", 64'(got.too_long), 64'(want.too_long));
        end
        plan_count++;
      end
      out_tready <= quiet_mode || $urandom_range(0, 99) >= 17;
    end
  end

  // stimulus and end of run
  initial begin
    factor_t f;
    int len;
    rst_n = 1'b0;
    quiet_mode = 1'b0;
    // directed: single factor, zeros, extremes, full chain, overflow, ties
    f = '{last: 1'b1, rows: 16'd0, cols: 16'd0};
    pending_factors = {pending_factors, f};
    f = '{last: 1'b1, rows: 16'hffff, cols: 16'hffff};
    pending_factors = {pending_factors, f};
    f = '{last: 1'b0, rows: 16'hffff, cols: 16'hffff};
    pending_factors = {pending_factors, f};
    pending_factors = {pending_factors, f};
    f.last = 1'b1;
    pending_factors = {pending_factors, f};
    for (int n = 0; n < 3; n++) begin
      f = '{last: (n == 2), rows: 16'd5, cols: 16'd5};
      pending_factors = {pending_factors, f};
    end
    add_chain(MAXC, 3);
    add_chain(MAXC + 3, 2);
    f = '{last: 1'b1, rows: 16'h0000, cols: 16'h0001};
    pending_factors = {pending_factors, f};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    // random chains, mostly short
    while (factor_count + pending_factors.size() < 1100) begin
      case ($urandom_range(0, 9))
        0: len = $urandom_range(MAXC + 1, MAXC + 4);
        1, 2: len = $urandom_range(9, MAXC);
        default: len = $urandom_range(1, 8);
      endcase
      add_chain(len, $urandom_range(0, 3));
      if (pending_factors.size() > 60) wait (pending_factors.size() < 30);
      if (factor_count > 400 && factor_count < 700) quiet_mode = 1'b1;
      else quiet_mode = 1'b0;
    end
    wait (pending_factors.size() == 0);
    wait (expected_plans.size() == 0);
    repeat (200) @(posedge clk);
    $display("covered %0d factors in %0d chains, including overflow and extreme dimensions",
             factor_count, plan_count);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #200ms;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule
